// File: src/sss_pkg.sv
`timescale 1ns / 1ps

package sss_pkg;

  typedef struct packed {
    logic        cmd;
    logic [23:0] score;
    logic        show_leading_zeros;
  } in_item_t;

  typedef struct packed {
    logic [2:0] scan_position;
    logic [6:0] segment_pattern;
    logic       frame_end;
  } out_item_t;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_SCAN = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_CONVERT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture a new score
    logic step;   // convert and write one digit
    logic scan;   // emit next position
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_digit;
    logic out_valid;
  } dp_status_t;

  // floor(v / 10) == (v * RECIP10) >> RECIP_SHIFT for any 24-bit v
  localparam logic [23:0] RECIP10     = 24'hCCCCCD;
  localparam int          RECIP_SHIFT = 27;

  localparam logic [2:0] POS_MAP7 [7] = '{3'd4, 3'd1, 3'd6, 3'd2, 3'd5, 3'd0, 3'd3};

  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] p;
    case (d)
      4'd0: p = 7'b1111110;
      4'd1: p = 7'b1010000;
      4'd2: p = 7'b1101101;
      4'd3: p = 7'b1011101;
      4'd4: p = 7'b1010011;
      4'd5: p = 7'b0011111;
      4'd6: p = 7'b0111111;
      4'd7: p = 7'b1011000;
      4'd8: p = 7'b1111111;
      4'd9: p = 7'b1011111;
      default: p = 7'b0000000;
    endcase
    return p;
  endfunction

endpackage

// File: src/seven_segment_score_scanner_top.sv
`timescale 1ns / 1ps
// Channel   Ports                            Direction
// input     in_valid, in_stall, in_data      in_data: in_item_t, in_stall driven here
// result    out_valid, out_stall, out_data   out_data: out_item_t, out_stall from sink
//
// Scan tick: the result lands in the output register in the cycle after the tick is taken.
// Set score: after acceptance the block converts all DIGITS digits in ST_CONVERT; the
// single divide-by-ten step converts one digit per cycle and in_stall is held meanwhile.
// in_stall is also high while a result waits in the output register under out_stall.
// Reset (rst_n low, synchronous) blanks both banks, makes bank zero front, clears
// the pending swap and restarts the scan at position 0.

module seven_segment_score_scanner_top import sss_pkg::*; #(
  parameter int DIGITS = 7
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  sss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  sss_datapath #(
    .DIGITS (DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_scan_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.cmd == CMD_SCAN) |=> out_valid)
    else $error("scan transfer produced no result");

  a_set_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.cmd == CMD_SET) |=> in_stall)
    else $error("input not held off during digit conversion");

  a_frame_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.frame_end) |-> (out_data.scan_position == 3'(DIGITS - 1)))
    else $error("frame end flagged at wrong position");
`endif

endmodule

// File: src/sss_ctrl.sv
`timescale 1ns / 1ps

module sss_ctrl import sss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_cmd,
  input  logic       out_stall,
  input  dp_status_t sts,
  output logic       in_stall,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    // a scan result needs the output register free (or draining this cycle)
    in_stall  = (state_r == ST_CONVERT) || (sts.out_valid && out_stall);
    accept    = in_valid && !in_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_SET) begin
            cmd.load  = 1'b1;
            state_nxt = ST_CONVERT;
          end else begin
            cmd.scan = 1'b1;
          end
        end
      end
      ST_CONVERT: begin
        cmd.step = 1'b1;
        if (sts.last_digit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: src/sss_datapath.sv
`timescale 1ns / 1ps

module sss_datapath import sss_pkg::*; #(
  parameter int DIGITS = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  logic       out_stall,
  input  dp_cmd_t    cmd,
  output dp_status_t sts,
  output logic       out_valid,
  output out_item_t  out_data
);

  localparam int DIG_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [DIG_W-1:0] LAST_IDX = DIG_W'(DIGITS - 1);

  logic [23:0]      val_r;
  logic             lz_r;
  logic [DIG_W-1:0] digit_r;
  logic [6:0]       banks_r [2][DIGITS];
  logic             front_r;
  logic             pending_r;
  logic [DIG_W-1:0] scan_idx_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic [47:0]      prod;
  logic [23:0]      quot;
  logic [23:0]      quot10;
  logic [3:0]       rem;
  logic [6:0]       pat;
  logic [DIG_W-1:0] pos;
  logic             last_digit;
  logic             scan_last;

  // one decimal digit per step: reciprocal multiply, then back-multiply by shifts
  assign prod   = {24'd0, val_r} * {24'd0, RECIP10};
  assign quot   = 24'(prod[47:RECIP_SHIFT]);
  assign quot10 = (quot << 3) + (quot << 1);
  assign rem    = 4'(val_r - quot10);
  assign pat    = (val_r != 24'd0 || digit_r == '0 || lz_r) ? seg_of(rem) : 7'd0;

  generate
    if (DIGITS == 7) begin : g_perm
      assign pos = DIG_W'(POS_MAP7[digit_r]);
    end else begin : g_ident
      assign pos = digit_r;
    end
  endgenerate

  assign last_digit = (digit_r == LAST_IDX);
  assign scan_last  = (scan_idx_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r   <= in_data.score;
      lz_r    <= in_data.show_leading_zeros;
      digit_r <= '0;
    end else if (cmd.step) begin
      val_r   <= quot;
      digit_r <= digit_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < 2; b++) begin
        for (int d = 0; d < DIGITS; d++) begin
          banks_r[b][d] <= 7'd0;
        end
      end
      front_r     <= 1'b0;
      pending_r   <= 1'b0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.step) begin
        banks_r[~front_r][pos] <= pat;
        if (last_digit) begin
          pending_r <= 1'b1;
        end
      end
      if (cmd.scan) begin
        out_valid_r <= 1'b1;
        if (scan_last) begin
          scan_idx_r <= '0;
          if (pending_r) begin
            front_r   <= ~front_r;
            pending_r <= 1'b0;
          end
        end else begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      out_r.scan_position   <= 3'(scan_idx_r);
      out_r.segment_pattern <= banks_r[front_r][scan_idx_r];
      out_r.frame_end       <= scan_last;
    end
  end

  assign sts.last_digit = last_digit;
  assign sts.out_valid  = out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sss_pkg::*;

  localparam logic [6:0] DIGIT_GLYPH [10] = '{
    7'b1111110, 7'b1010000, 7'b1101101, 7'b1011101, 7'b1010011,
    7'b0011111, 7'b0111111, 7'b1011000, 7'b1111111, 7'b1011111
  };
  // display position of each decimal digit, least significant first
  localparam int DIGIT_SLOT [7] = '{4, 1, 6, 2, 5, 0, 3};
  localparam int NUM_POS = 7;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // display state as the block should hold it
  logic [6:0] seg_bank [2][NUM_POS];
  logic       front_sel;
  logic       swap_due;
  int         next_pos;
  out_item_t  frame_q [$];

  int errors = 0;
  int n_sets = 0;
  int n_scans = 0;
  int n_frames = 0;
  int n_checked = 0;

  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int gap_max = 0;
  int burst_left = 0;

  seven_segment_score_scanner_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d results still expected", frame_q.size());
    $display("** seven_segment_score_scanner_top: FAILED **");
    $finish;
  end

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic predict_item(input in_item_t it);
    int unsigned v;
    logic        back;
    logic [6:0]  pat;
    out_item_t   want;
    if (it.cmd == CMD_SET) begin
      v = {8'd0, it.score};
      back = ~front_sel;
      for (int i = 0; i < NUM_POS; i++) begin
        pat = (v != 0 || i == 0 || it.show_leading_zeros) ? DIGIT_GLYPH[v % 10] : 7'd0;
        seg_bank[back][DIGIT_SLOT[i]] = pat;
        v = v / 10;
      end
      swap_due = 1'b1;
      n_sets++;
    end else begin
      want.scan_position = 3'(next_pos);
      want.segment_pattern = seg_bank[front_sel][next_pos];
      want.frame_end = (next_pos == NUM_POS - 1);
      frame_q.push_back(want);
      n_scans++;
      if (want.frame_end) begin
        next_pos = 0;
        n_frames++;
        if (swap_due) begin
          front_sel = ~front_sel;
          swap_due = 1'b0;
        end
      end else begin
        next_pos++;
      end
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (frame_q.size() == 0) begin
      flag_error($sformatf("unexpected result pos=%0d seg=%b end=%b",
                           got.scan_position, got.segment_pattern, got.frame_end));
    end else begin
      want = frame_q.pop_front();
      n_checked++;
      if (got.scan_position !== want.scan_position)
        flag_error($sformatf("scan_position %0d, expected %0d",
                             got.scan_position, want.scan_position));
      if (got.segment_pattern !== want.segment_pattern)
        flag_error($sformatf("segment_pattern %b at pos %0d, expected %b",
                             got.segment_pattern, want.scan_position,
                             want.segment_pattern));
      if (got.frame_end !== want.frame_end)
        flag_error($sformatf("frame_end %b at pos %0d, expected %b",
                             got.frame_end, want.scan_position, want.frame_end));
    end
  endtask

  // results are retired before the new input so an empty queue is never misread
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) predict_item(in_data);
    end
  end

  // sink: random stall pattern, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_pct == 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic in_item_t make_item(input logic cmd, input int unsigned score,
                                         input logic lz);
    in_item_t it;
    it.cmd = cmd;
    it.score = 24'(score);
    it.show_leading_zeros = lz;
    return it;
  endfunction

  function automatic in_item_t random_item(input int scan_pct);
    in_item_t    it;
    int unsigned p;
    it.cmd = ($urandom_range(99) < scan_pct) ? CMD_SCAN : CMD_SET;
    case ($urandom_range(4))
      0: it.score = 24'($urandom_range(999));
      1: it.score = 24'($urandom());
      2: it.score = 24'($urandom_range(9999999));
      3: begin
        // sparse values: at most one nonzero digit, lots of leading and inner zeros
        p = 1;
        repeat ($urandom_range(6)) p = p * 10;
        it.score = 24'(p * $urandom_range(9));
      end
      default: it.score = 24'($urandom_range(16777215, 10000000));
    endcase
    it.show_leading_zeros = 1'($urandom_range(1));
    return it;
  endfunction

  // holds valid across back-to-back items; pace_sender and the test tasks lower it
  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
  endtask

  task automatic send_frame_of_scans();
    repeat (NUM_POS) send_item(make_item(CMD_SCAN, $urandom(), 1'($urandom_range(1))));
  endtask

  task automatic test_directed();
    // blank display from reset, ignored fields carry junk
    send_frame_of_scans();
    // zero with blanking, then overwritten while the swap is still pending
    send_item(make_item(CMD_SET, 0, 1'b0));
    send_item(make_item(CMD_SET, 24'hFFFFFF, 1'b0));
    send_frame_of_scans();
    // value too long for seven digits, so every shown digit is zero, then a short value with leading zeros shown
    send_item(make_item(CMD_SET, 10000000, 1'b0));
    send_item(make_item(CMD_SET, 305, 1'b1));
    send_frame_of_scans();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_random_mix(input int count, input int gaps, input int stall,
                                 input int scan_pct);
    gap_max = gaps;
    stall_pct = stall;
    burst_left = 0;
    repeat (count) begin
      send_item(random_item(scan_pct));
      pace_sender();
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_receiver_holdoff();
    stall_pct = 0;
    hold_request = 250;
    repeat (40) send_item(random_item(90));
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_streaming();
    // no idling on either side
    test_random_mix(250, 0, 0, 80);
  endtask

  initial begin
    for (int b = 0; b < 2; b++)
      for (int p = 0; p < NUM_POS; p++) seg_bank[b][p] = 7'd0;
    front_sel = 1'b0;
    swap_due = 1'b0;
    next_pos = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mix(400, 5, 30, 80);
    test_random_mix(300, 2, 70, 85);
    test_receiver_holdoff();
    test_streaming();
    test_random_mix(330, 8, 10, 75);

    stall_pct = 0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d score loads and %0d scan ticks (%0d full frames), %0d results checked",
             n_sets, n_scans, n_frames, n_checked);
    $display("random stall/gap mixes, a 250-cycle sink hold-off and a no-idle stretch");
    if (errors == 0) begin
      $display("** seven_segment_score_scanner_top: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** seven_segment_score_scanner_top: FAILED **");
    end
    $finish;
  end

endmodule
